/* hdl/shpf_pkg.sv */
`default_nettype none

package shpf_pkg;

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Frame sync bytes.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Command queue geometry (depth is a power of two, pointers wrap naturally).
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_e;

  // One command handed from the front end to the back end.
  // For a start, b0 is the class, b1 the id, len the payload length and
  // flag marks a zero-length packet. For a data byte, b0 is the byte and
  // flag marks the last payload byte of the packet.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] len;
    logic        flag;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/shpf_front.sv */
`default_nettype none

module shpf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          op_i,
  input  wire logic [7:0]    msg_class_i,
  input  wire logic [7:0]    msg_id_i,
  input  wire logic [15:0]   payload_length_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          q_full_i,
  output logic               cmd_valid_o,
  output shpf_pkg::cmd_t     cmd_o
);
  import shpf_pkg::*;

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic        accept;

  // Take a word whenever the queue has room; dropped bytes need no room but
  // keeping ready simple costs nothing at the sustained rate.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the word and track the open packet.
  always_comb begin
    open_d      = open_q;
    left_d      = left_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_START;
    cmd_o.b0    = msg_class_i;
    cmd_o.b1    = msg_id_i;
    cmd_o.len   = payload_length_i;
    cmd_o.flag  = (payload_length_i == 16'd0);
    if (accept) begin
      if (op_i == OP_START) begin
        cmd_valid_o = 1'b1;
        open_d      = (payload_length_i != 16'd0);
        left_d      = payload_length_i;
      end else if (open_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_DATA;
        cmd_o.b0    = data_byte_i;
        cmd_o.flag  = (left_q == 16'd1);
        left_d      = left_q - 16'd1;
        open_d      = (left_q != 16'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 16'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/shpf_queue.sv */
`default_nettype none

module shpf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire shpf_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               head_valid_o,
  output shpf_pkg::cmd_t     head_o,
  input  wire logic          pop_i
);
  import shpf_pkg::*;

  cmd_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entries_q[rd_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/shpf_back.sv */
`default_nettype none

module shpf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire shpf_pkg::cmd_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               end_of_packet_o,
  output logic               last_of_run_o
);
  import shpf_pkg::*;

  logic [2:0] step_q, step_d;
  logic [7:0] sum_a_q, sum_a_d;
  logic [7:0] sum_b_q, sum_b_d;
  logic       summed;
  logic       fire;

  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i && out_ready_i;
  assign pop_o       = fire && last_of_run_o;

  // Select the byte for the current step of the head command.
  always_comb begin
    out_byte_o      = 8'h00;
    end_of_packet_o = 1'b0;
    last_of_run_o   = 1'b0;
    summed          = 1'b0;
    if (head_i.kind == CMD_START) begin
      case (step_q)
        3'd0: out_byte_o = SYNC_FIRST;
        3'd1: out_byte_o = SYNC_SECOND;
        3'd2: begin
          out_byte_o = head_i.b0;
          summed     = 1'b1;
        end
        3'd3: begin
          out_byte_o = head_i.b1;
          summed     = 1'b1;
        end
        3'd4: begin
          out_byte_o = head_i.len[7:0];
          summed     = 1'b1;
        end
        3'd5: begin
          out_byte_o    = head_i.len[15:8];
          summed        = 1'b1;
          last_of_run_o = !head_i.flag;
        end
        3'd6: out_byte_o = sum_a_q;
        3'd7: begin
          out_byte_o      = sum_b_q;
          end_of_packet_o = 1'b1;
          last_of_run_o   = 1'b1;
        end
        default: out_byte_o = 8'h00;
      endcase
    end else begin
      case (step_q)
        3'd0: begin
          out_byte_o    = head_i.b0;
          summed        = 1'b1;
          last_of_run_o = !head_i.flag;
        end
        3'd1: out_byte_o = sum_a_q;
        3'd2: begin
          out_byte_o      = sum_b_q;
          end_of_packet_o = 1'b1;
          last_of_run_o   = 1'b1;
        end
        default: out_byte_o = 8'h00;
      endcase
    end
  end

  // Step counter and running checksum, advanced on each delivered word.
  always_comb begin
    step_d  = step_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (fire) begin
      step_d = last_of_run_o ? 3'd0 : step_q + 3'd1;
      if (head_i.kind == CMD_START && step_q == 3'd0) begin
        sum_a_d = 8'h00;
        sum_b_d = 8'h00;
      end else if (summed) begin
        sum_a_d = sum_a_q + out_byte_o;
        sum_b_d = sum_b_q + sum_a_d;
      end else if (end_of_packet_o) begin
        sum_a_d = 8'h00;
        sum_b_d = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      sum_a_q <= 8'h00;
      sum_b_q <= 8'h00;
    end else begin
      step_q  <= step_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/sync_header_packet_framer_unit.sv */
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    op, msg_class, msg_id, payload_length, data_byte
// out      output     out_valid_o / out_ready_i  out_byte, end_of_packet, last_of_run
//
// The front end takes one input word per cycle while the four-entry command queue has room.
// The back end sends one byte per cycle from the queue head while out_ready_i is high:
// a start gives sync, class, id, length; a data byte gives itself; the checksum ends a packet.
// Payload bytes with no open packet are accepted and dropped without output.
// Reset clears the open packet, the queue and the checksum at once; no clearing pass.
// A stalled output fills the queue, and only then is the input held off.
module sync_header_packet_framer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  msg_class_i,
  input  wire logic [7:0]  msg_id_i,
  input  wire logic [15:0] payload_length_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             end_of_packet_o,
  output logic             last_of_run_o
);
  import shpf_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  // Front end: accept and classify input words.
  shpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .msg_class_i      (msg_class_i),
    .msg_id_i         (msg_id_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd)
  );

  // Command queue between the two halves.
  shpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_valid),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back end: expand commands into framed bytes.
  shpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .end_of_packet_o (end_of_packet_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
